@@ rtl/trms_pkg.sv @@
package trms_pkg;

    localparam int SAMPLE_BITS_DEFAULT = 12;
    localparam int COUNT_BITS_DEFAULT  = 16;

    localparam int SQ_SUM_BITS     = 56;
    localparam int PLAIN_SUM_BITS  = 28;
    localparam int WIN_LEN_BITS    = 16;
    localparam int GAIN_BITS       = 24;
    localparam int THR_BITS        = 32;
    localparam int CFG_DATA_BITS   = 32;
    localparam int CFG_INDEX_BITS  = 2;
    localparam int CURRENT_BITS    = 32;
    localparam int OFFSET_OUT_BITS = 20;

    localparam int WIDE_BITS     = 64;
    localparam int MUL_BITS      = 32;
    localparam int SQRT_REM_BITS = 34;
    localparam int ROOT_BITS     = 32;
    localparam int ITER_BITS     = 6;
    localparam int DIV_STEPS     = 64;
    localparam int SQRT_STEPS    = 32;

    // 3.3 V / 4095 counts in Q0.32
    localparam logic [MUL_BITS-1:0] VOLT_PER_COUNT_Q32 = 32'd3461146;

    localparam logic [WIN_LEN_BITS-1:0] WIN_LEN_RESET = 16'd4096;
    localparam logic [GAIN_BITS-1:0]    GAIN_RESET    = 24'd65536;
    localparam logic [THR_BITS-1:0]     THR_RESET     = 32'd3277;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_LENGTH    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CALIBRATION_GAIN = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_NOISE_THRESHOLD  = 2'd2;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_ACCEPT,
        CMD_SQUARE,
        CMD_ACCUM,
        CMD_LD_MEAN,
        CMD_MUL_LO,
        CMD_MUL_HI,
        CMD_MUL_SUM,
        CMD_VAR,
        CMD_DIV_STEP,
        CMD_SHIFT16,
        CMD_LD_SQRT,
        CMD_SQRT_STEP,
        CMD_MUL_VOLT,
        CMD_VOLT,
        CMD_MUL_AMP,
        CMD_AMP,
        CMD_SET_BASE,
        CMD_LD_OFS,
        CMD_SET_OFS,
        CMD_RESULT
    } cmd_t;

    typedef struct packed {
        logic win_mode;
        logic win_last;
        logic div_last;
        logic sqrt_last;
    } dp_status_t;

endpackage

@@ rtl/trms_in_if.sv @@
interface trms_in_if
    import trms_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) ();
    logic                   valid;
    logic                   ready;
    logic                   mode;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output mode, output sample, input ready);
    modport sink (input valid, input mode, input sample, output ready);
endinterface

@@ rtl/trms_out_if.sv @@
interface trms_out_if
    import trms_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [CURRENT_BITS-1:0]    current_rms;
    logic                       is_calibration;
    logic [OFFSET_OUT_BITS-1:0] offset_now;
    logic [CURRENT_BITS-1:0]    baseline_now;

    modport source (
        output valid, output current_rms, output is_calibration,
        output offset_now, output baseline_now, input ready
    );
    modport sink (
        input valid, input current_rms, input is_calibration,
        input offset_now, input baseline_now, output ready
    );
endinterface

@@ rtl/trms_dp.sv @@
module trms_dp
    import trms_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
    parameter int COUNT_BITS  = COUNT_BITS_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [CFG_DATA_BITS-1:0]    cfg_data,
    input  cmd_t                        cmd,
    output dp_status_t                  status,
    input  logic                        mode,
    input  logic [SAMPLE_BITS-1:0]      sample,
    output logic [CURRENT_BITS-1:0]     current_rms,
    output logic                        is_calibration,
    output logic [OFFSET_OUT_BITS-1:0]  offset_now,
    output logic [CURRENT_BITS-1:0]     baseline_now
);

    localparam int OP_BITS  = SAMPLE_BITS + 8;
    localparam int LEN_BITS = (COUNT_BITS > WIN_LEN_BITS) ? COUNT_BITS : WIN_LEN_BITS;
    localparam logic [LEN_BITS-1:0] CNT_MAX = LEN_BITS'({COUNT_BITS{1'b1}});

    // configuration
    logic [WIN_LEN_BITS-1:0] win_len_reg, win_len_next;
    logic [GAIN_BITS-1:0]    gain_reg, gain_next;
    logic [THR_BITS-1:0]     thr_reg, thr_next;

    // window state
    logic [SQ_SUM_BITS-1:0]    acc_sq_reg, acc_sq_next;
    logic [PLAIN_SUM_BITS-1:0] acc_sum_reg, acc_sum_next;
    logic [COUNT_BITS-1:0]     cnt_reg, cnt_next;
    logic                      win_mode_reg, win_mode_next;
    logic [OP_BITS-1:0]        offset_reg, offset_next;
    logic [CURRENT_BITS-1:0]   baseline_reg, baseline_next;
    logic [ITER_BITS-1:0]      iter_reg, iter_next;

    // work registers
    logic [OP_BITS-1:0]       op_reg, op_next;
    logic [SAMPLE_BITS-1:0]   smp_reg, smp_next;
    logic [WIDE_BITS-1:0]     prod_reg, prod_next;
    logic [WIDE_BITS-1:0]     x_reg, x_next;
    logic [WIDE_BITS-1:0]     y_reg, y_next;
    logic [COUNT_BITS-1:0]    div_rem_reg, div_rem_next;
    logic [SQRT_REM_BITS-1:0] sq_rem_reg, sq_rem_next;
    logic [ROOT_BITS-1:0]     root_reg, root_next;

    // result beat
    logic [CURRENT_BITS-1:0]    cur_out_reg, cur_out_next;
    logic                       is_cal_reg, is_cal_next;
    logic [OFFSET_OUT_BITS-1:0] ofs_out_reg, ofs_out_next;
    logic [CURRENT_BITS-1:0]    base_out_reg, base_out_next;

    // combinational helpers
    logic                      mode_eff;
    logic [OP_BITS-1:0]        smp_scaled;
    logic [OP_BITS-1:0]        smp_dist;
    logic [LEN_BITS-1:0]       wl_ext;
    logic [LEN_BITS-1:0]       len_eff;
    logic [MUL_BITS-1:0]       mul_a, mul_b;
    logic [WIDE_BITS-1:0]      mul_p;
    logic [COUNT_BITS:0]       div_sh, div_diff;
    logic                      div_ge;
    logic [SQRT_REM_BITS+1:0]  sq_sh, sq_trial, sq_diff;
    logic                      sq_ge;
    logic [WIDE_BITS-1:0]      amp_diff, amp_gated;
    logic [CURRENT_BITS-1:0]   amp_sat, base_sat;
    logic [WIDE_BITS-1:0]      var_sum;

    assign mode_eff   = (cnt_reg == '0) ? mode : win_mode_reg;
    assign smp_scaled = {sample, 8'b0};
    assign smp_dist   = (smp_scaled >= offset_reg) ? smp_scaled - offset_reg
                                                   : offset_reg - smp_scaled;

    always_comb
    begin
        wl_ext = LEN_BITS'(win_len_reg);
        if (wl_ext == '0)
        begin
            len_eff = LEN_BITS'(1);
        end
        else if (wl_ext > CNT_MAX)
        begin
            len_eff = CNT_MAX;
        end
        else
        begin
            len_eff = wl_ext;
        end
    end

    assign mul_p = mul_a * mul_b;

    // restoring divide by the sample count, one quotient bit per step
    assign div_sh   = {div_rem_reg, x_reg[WIDE_BITS-1]};
    assign div_diff = div_sh - {1'b0, cnt_reg};
    assign div_ge   = div_sh >= {1'b0, cnt_reg};

    // digit-by-digit square root, one root bit per step
    assign sq_sh    = {sq_rem_reg, x_reg[WIDE_BITS-1 -: 2]};
    assign sq_trial = {2'b00, root_reg, 2'b01};
    assign sq_diff  = sq_sh - sq_trial;
    assign sq_ge    = sq_sh >= sq_trial;

    assign amp_diff  = (x_reg > WIDE_BITS'(baseline_reg)) ? x_reg - WIDE_BITS'(baseline_reg)
                                                          : '0;
    assign amp_gated = (amp_diff < WIDE_BITS'(thr_reg)) ? '0 : amp_diff;
    assign amp_sat   = (amp_gated[WIDE_BITS-1:CURRENT_BITS] != '0) ? '1
                                                                   : amp_gated[CURRENT_BITS-1:0];
    assign base_sat  = (x_reg[WIDE_BITS-1:CURRENT_BITS] != '0) ? '1 : x_reg[CURRENT_BITS-1:0];
    assign var_sum   = y_reg + {prod_reg[MUL_BITS-1:0], {MUL_BITS{1'b0}}};

    always_comb
    begin
        win_len_next  = win_len_reg;
        gain_next     = gain_reg;
        thr_next      = thr_reg;
        acc_sq_next   = acc_sq_reg;
        acc_sum_next  = acc_sum_reg;
        cnt_next      = cnt_reg;
        win_mode_next = win_mode_reg;
        offset_next   = offset_reg;
        baseline_next = baseline_reg;
        iter_next     = iter_reg;
        op_next       = op_reg;
        smp_next      = smp_reg;
        prod_next     = prod_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        div_rem_next  = div_rem_reg;
        sq_rem_next   = sq_rem_reg;
        root_next     = root_reg;
        cur_out_next  = cur_out_reg;
        is_cal_next   = is_cal_reg;
        ofs_out_next  = ofs_out_reg;
        base_out_next = base_out_reg;
        mul_a         = '0;
        mul_b         = '0;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WINDOW_LENGTH:    win_len_next = cfg_data[WIN_LEN_BITS-1:0];
                CFG_CALIBRATION_GAIN: gain_next    = cfg_data[GAIN_BITS-1:0];
                CFG_NOISE_THRESHOLD:  thr_next     = cfg_data[THR_BITS-1:0];
                default:              ;
            endcase
        end

        case (cmd)
            CMD_ACCEPT:
            begin
                smp_next      = sample;
                win_mode_next = mode_eff;
                op_next       = mode_eff ? OP_BITS'(sample) : smp_dist;
            end
            CMD_SQUARE:
            begin
                mul_a     = MUL_BITS'(op_reg);
                mul_b     = MUL_BITS'(op_reg);
                prod_next = mul_p;
                cnt_next  = cnt_reg + COUNT_BITS'(1);
            end
            CMD_ACCUM:
            begin
                acc_sq_next = acc_sq_reg + prod_reg[SQ_SUM_BITS-1:0];
                if (win_mode_reg)
                begin
                    acc_sum_next = acc_sum_reg + PLAIN_SUM_BITS'(smp_reg);
                end
            end
            CMD_LD_MEAN:
            begin
                x_next       = WIDE_BITS'(acc_sq_reg);
                div_rem_next = '0;
                iter_next    = '0;
            end
            CMD_MUL_LO:
            begin
                mul_a     = MUL_BITS'(cnt_reg);
                mul_b     = acc_sq_reg[MUL_BITS-1:0];
                prod_next = mul_p;
            end
            CMD_MUL_HI:
            begin
                y_next    = prod_reg;
                mul_a     = MUL_BITS'(cnt_reg);
                mul_b     = MUL_BITS'(acc_sq_reg[SQ_SUM_BITS-1:MUL_BITS]);
                prod_next = mul_p;
            end
            CMD_MUL_SUM:
            begin
                y_next    = var_sum;
                mul_a     = MUL_BITS'(acc_sum_reg);
                mul_b     = MUL_BITS'(acc_sum_reg);
                prod_next = mul_p;
            end
            CMD_VAR:
            begin
                x_next       = (y_reg > prod_reg) ? y_reg - prod_reg : '0;
                div_rem_next = '0;
                iter_next    = '0;
            end
            CMD_DIV_STEP:
            begin
                div_rem_next = div_ge ? div_diff[COUNT_BITS-1:0] : div_sh[COUNT_BITS-1:0];
                x_next       = {x_reg[WIDE_BITS-2:0], div_ge};
                iter_next    = iter_reg + ITER_BITS'(1);
            end
            CMD_SHIFT16:
            begin
                x_next       = {x_reg[WIDE_BITS-17:0], 16'b0};
                div_rem_next = '0;
                iter_next    = '0;
            end
            CMD_LD_SQRT:
            begin
                x_next      = {x_reg[WIDE_BITS-17:0], 16'b0};
                sq_rem_next = '0;
                root_next   = '0;
                iter_next   = '0;
            end
            CMD_SQRT_STEP:
            begin
                sq_rem_next = sq_ge ? sq_diff[SQRT_REM_BITS-1:0] : sq_sh[SQRT_REM_BITS-1:0];
                root_next   = {root_reg[ROOT_BITS-2:0], sq_ge};
                x_next      = {x_reg[WIDE_BITS-3:0], 2'b00};
                iter_next   = iter_reg + ITER_BITS'(1);
            end
            CMD_MUL_VOLT:
            begin
                mul_a     = root_reg;
                mul_b     = VOLT_PER_COUNT_Q32;
                prod_next = mul_p;
            end
            CMD_VOLT:
            begin
                // round to nearest, drop the Q0.32 fraction
                x_next = WIDE_BITS'(prod_reg[WIDE_BITS-1:31] + 33'd1) >> 1;
            end
            CMD_MUL_AMP:
            begin
                mul_a     = x_reg[MUL_BITS-1:0];
                mul_b     = MUL_BITS'(gain_reg);
                prod_next = mul_p;
            end
            CMD_AMP:
            begin
                x_next = WIDE_BITS'(prod_reg[WIDE_BITS-1:15] + 49'd1) >> 1;
            end
            CMD_SET_BASE:
            begin
                baseline_next = base_sat;
            end
            CMD_LD_OFS:
            begin
                x_next       = WIDE_BITS'({acc_sum_reg, 8'b0});
                div_rem_next = '0;
                iter_next    = '0;
            end
            CMD_SET_OFS:
            begin
                offset_next = x_reg[OP_BITS-1:0];
            end
            CMD_RESULT:
            begin
                cur_out_next  = win_mode_reg ? '0 : amp_sat;
                is_cal_next   = win_mode_reg;
                ofs_out_next  = OFFSET_OUT_BITS'(offset_reg);
                base_out_next = baseline_reg;
                acc_sq_next   = '0;
                acc_sum_next  = '0;
                cnt_next      = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_len_reg  <= WIN_LEN_RESET;
            gain_reg     <= GAIN_RESET;
            thr_reg      <= THR_RESET;
            acc_sq_reg   <= '0;
            acc_sum_reg  <= '0;
            cnt_reg      <= '0;
            win_mode_reg <= 1'b0;
            offset_reg   <= '0;
            baseline_reg <= '0;
            iter_reg     <= '0;
        end
        else
        begin
            win_len_reg  <= win_len_next;
            gain_reg     <= gain_next;
            thr_reg      <= thr_next;
            acc_sq_reg   <= acc_sq_next;
            acc_sum_reg  <= acc_sum_next;
            cnt_reg      <= cnt_next;
            win_mode_reg <= win_mode_next;
            offset_reg   <= offset_next;
            baseline_reg <= baseline_next;
            iter_reg     <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        smp_reg      <= smp_next;
        prod_reg     <= prod_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        div_rem_reg  <= div_rem_next;
        sq_rem_reg   <= sq_rem_next;
        root_reg     <= root_next;
        cur_out_reg  <= cur_out_next;
        is_cal_reg   <= is_cal_next;
        ofs_out_reg  <= ofs_out_next;
        base_out_reg <= base_out_next;
    end

    assign status.win_mode  = win_mode_reg;
    assign status.win_last  = LEN_BITS'(cnt_reg) >= len_eff;
    assign status.div_last  = iter_reg == ITER_BITS'(DIV_STEPS - 1);
    assign status.sqrt_last = iter_reg == ITER_BITS'(SQRT_STEPS - 1);

    assign current_rms    = cur_out_reg;
    assign is_calibration = is_cal_reg;
    assign offset_now     = ofs_out_reg;
    assign baseline_now   = base_out_reg;

endmodule

@@ rtl/trms_ctrl.sv @@
module trms_ctrl
    import trms_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output cmd_t       cmd,
    input  dp_status_t status
);

    typedef enum logic [22:0] {
        ST_IDLE     = 23'h000001,
        ST_SQUARE   = 23'h000002,
        ST_ACCUM    = 23'h000004,
        ST_LD_MEAN  = 23'h000008,
        ST_DIV_MEAN = 23'h000010,
        ST_MUL_LO   = 23'h000020,
        ST_MUL_HI   = 23'h000040,
        ST_MUL_SUM  = 23'h000080,
        ST_VAR      = 23'h000100,
        ST_DIV_VAR1 = 23'h000200,
        ST_SHIFT    = 23'h000400,
        ST_DIV_VAR2 = 23'h000800,
        ST_LD_SQRT  = 23'h001000,
        ST_SQRT     = 23'h002000,
        ST_MUL_VOLT = 23'h004000,
        ST_VOLT     = 23'h008000,
        ST_MUL_AMP  = 23'h010000,
        ST_AMP      = 23'h020000,
        ST_SET_BASE = 23'h040000,
        ST_LD_OFS   = 23'h080000,
        ST_DIV_OFS  = 23'h100000,
        ST_SET_OFS  = 23'h200000,
        ST_RESULT   = 23'h400000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = CMD_NONE;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd        = CMD_ACCEPT;
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                cmd        = CMD_SQUARE;
                state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                cmd = CMD_ACCUM;
                if (!status.win_last)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.win_mode)
                begin
                    state_next = ST_MUL_LO;
                end
                else
                begin
                    state_next = ST_LD_MEAN;
                end
            end
            ST_LD_MEAN:
            begin
                cmd        = CMD_LD_MEAN;
                state_next = ST_DIV_MEAN;
            end
            ST_DIV_MEAN:
            begin
                cmd = CMD_DIV_STEP;
                if (status.div_last)
                begin
                    state_next = ST_LD_SQRT;
                end
            end
            ST_MUL_LO:
            begin
                cmd        = CMD_MUL_LO;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                cmd        = CMD_MUL_HI;
                state_next = ST_MUL_SUM;
            end
            ST_MUL_SUM:
            begin
                cmd        = CMD_MUL_SUM;
                state_next = ST_VAR;
            end
            ST_VAR:
            begin
                cmd        = CMD_VAR;
                state_next = ST_DIV_VAR1;
            end
            ST_DIV_VAR1:
            begin
                cmd = CMD_DIV_STEP;
                if (status.div_last)
                begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                cmd        = CMD_SHIFT16;
                state_next = ST_DIV_VAR2;
            end
            ST_DIV_VAR2:
            begin
                cmd = CMD_DIV_STEP;
                if (status.div_last)
                begin
                    state_next = ST_LD_SQRT;
                end
            end
            ST_LD_SQRT:
            begin
                cmd        = CMD_LD_SQRT;
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                cmd = CMD_SQRT_STEP;
                if (status.sqrt_last)
                begin
                    state_next = ST_MUL_VOLT;
                end
            end
            ST_MUL_VOLT:
            begin
                cmd        = CMD_MUL_VOLT;
                state_next = ST_VOLT;
            end
            ST_VOLT:
            begin
                cmd        = CMD_VOLT;
                state_next = ST_MUL_AMP;
            end
            ST_MUL_AMP:
            begin
                cmd        = CMD_MUL_AMP;
                state_next = ST_AMP;
            end
            ST_AMP:
            begin
                cmd        = CMD_AMP;
                state_next = status.win_mode ? ST_SET_BASE : ST_RESULT;
            end
            ST_SET_BASE:
            begin
                cmd        = CMD_SET_BASE;
                state_next = ST_LD_OFS;
            end
            ST_LD_OFS:
            begin
                cmd        = CMD_LD_OFS;
                state_next = ST_DIV_OFS;
            end
            ST_DIV_OFS:
            begin
                cmd = CMD_DIV_STEP;
                if (status.div_last)
                begin
                    state_next = ST_SET_OFS;
                end
            end
            ST_SET_OFS:
            begin
                cmd        = CMD_SET_OFS;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd            = CMD_RESULT;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ rtl/true_rms_current_meter.sv @@
// True-RMS current meter with zero-offset and baseline calibration.
// samples: valid/ready channel of ADC beats (mode, sample). results: one beat
// per closed window (current_rms, is_calibration, offset_now, baseline_now).
// cfg_we/cfg_index/cfg_data write window_length, calibration_gain and
// noise_threshold; write them only while the block is idle.
// Each sample passes through accept, square and accumulate steps, using the one
// shared 32x32 multiplier. The last sample of a window then runs the end
// sequence before the result beat: measure windows take one pass of the
// 64-step divider and one of the 32-step square root, calibration windows
// three passes of the divider and one of the root.
// The result sits in an output register; new samples are taken while it waits.
// If the receiver still stalls when the next window closes, the block holds
// that result and takes no sample until the register frees.
// Reset clears the sums, sample count, offset and baseline, loads the
// register defaults (4096 samples, gain 1.0, threshold 3277) and drops valid.
module true_rms_current_meter
    import trms_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
    parameter int COUNT_BITS  = COUNT_BITS_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    trms_in_if.sink                   samples,
    trms_out_if.source                results
);

    cmd_t       cmd;
    dp_status_t status;

    trms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .cmd       (cmd),
        .status    (status)
    );

    trms_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .cmd            (cmd),
        .status         (status),
        .mode           (samples.mode),
        .sample         (samples.sample),
        .current_rms    (results.current_rms),
        .is_calibration (results.is_calibration),
        .offset_now     (results.offset_now),
        .baseline_now   (results.baseline_now)
    );

endmodule

@@ tb/tb_true_rms_current_meter.sv @@
`timescale 1ns / 100ps

module tb_true_rms_current_meter
    import trms_pkg::*;
();

    localparam logic MODE_MEASURE   = 1'b0;
    localparam logic MODE_CALIBRATE = 1'b1;

    localparam logic [63:0] VOLTS_PER_LSB_Q32 = 64'd3461146;
    localparam logic [31:0] NOISE_MAX         = 32'hFFFF_FFFF;
    localparam logic [31:0] GAIN_MAX          = 32'h00FF_FFFF;
    localparam logic [31:0] TAIL_WINDOW       = 32'd16;

    localparam int unsigned SETTLE_CYCLES  = 300;
    localparam int unsigned HOLD_CYCLES    = 1000;
    localparam int unsigned WATCHDOG_LIMIT = 20000;
    localparam int unsigned RANDOM_PHASES  = 12;
    localparam int unsigned PHASE_BEATS    = 65;

    typedef enum int {SHAPE_CLUSTER, SHAPE_SPREAD, SHAPE_RAILS} sample_shape_t;

    typedef struct packed {
        logic [31:0] current_rms;
        logic        is_calibration;
        logic [19:0] offset_now;
        logic [31:0] baseline_now;
    } reading_t;

    typedef struct {
        bit                        is_cfg;
        logic [CFG_INDEX_BITS-1:0] reg_index;
        logic [31:0]               reg_value;
        logic                      mode;
        logic [11:0]               sample;
        bit                        known;
        reading_t                  want;
    } dir_row_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    trms_in_if  smp_if ();
    trms_out_if res_if ();

    true_rms_current_meter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (smp_if),
        .results   (res_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow copy of the meter: registers and window state
    logic [15:0] win_len  = 16'd4096;
    logic [23:0] gain     = 24'd65536;
    logic [31:0] noise    = 32'd3277;
    logic [55:0] sq_acc   = '0;
    logic [27:0] sum_acc  = '0;
    logic [15:0] win_cnt  = '0;
    logic        win_mode = 1'b0;
    logic [19:0] zero_ofs = '0;
    logic [31:0] base_rms = '0;

    reading_t    pending_readings[$];
    int unsigned bad_readings = 0;
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_idle_pct  = 0;
    bit          hold_req     = 1'b0;

    function automatic logic [63:0] floor_root(input logic [63:0] x);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] trial;
        rem  = '0;
        root = '0;
        for (int i = 31; i >= 0; i--)
        begin
            rem   = (rem << 2) | ((x >> (2 * i)) & 64'd3);
            trial = (root << 2) | 64'd1;
            if (rem >= trial)
            begin
                rem  = rem - trial;
                root = (root << 1) | 64'd1;
            end
            else
                root = root << 1;
        end
        return root;
    endfunction

    // Q.16 RMS counts -> Q16.16 amps, unsaturated
    function automatic logic [63:0] counts_to_amps(input logic [63:0] r);
        logic [63:0] volts;
        volts = (r * VOLTS_PER_LSB_Q32 + 64'h8000_0000) >> 32;
        return (volts * 64'(gain) + 64'h8000) >> 16;
    endfunction

    function automatic logic [31:0] clip32(input logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    // advances the shadow state by one sample; 1 when the window closes
    function automatic bit rms_predict(input logic m, input logic [11:0] s,
                                       output reading_t r);
        logic [63:0] len;
        logic [63:0] n;
        logic [63:0] a;
        logic [63:0] d;
        logic [63:0] p;
        logic [63:0] q;
        logic [63:0] t;
        logic [63:0] v;
        logic [63:0] amps;
        r   = '0;
        len = (win_len == 0) ? 64'd1 : 64'(win_len);
        if (win_cnt == 0)
            win_mode = m;
        if (win_mode == MODE_MEASURE)
        begin
            a      = 64'(s) << 8;
            d      = (a >= 64'(zero_ofs)) ? a - 64'(zero_ofs) : 64'(zero_ofs) - a;
            sq_acc = 56'(64'(sq_acc) + d * d);
        end
        else
        begin
            sum_acc = 28'(64'(sum_acc) + 64'(s));
            sq_acc  = 56'(64'(sq_acc) + 64'(s) * 64'(s));
        end
        win_cnt = win_cnt + 16'd1;
        if (64'(win_cnt) < len)
            return 1'b0;

        n = 64'(win_cnt);
        if (win_mode == MODE_MEASURE)
        begin
            amps = counts_to_amps(floor_root((64'(sq_acc) / n) << 16));
            amps = (amps > 64'(base_rms)) ? amps - 64'(base_rms) : 64'd0;
            if (amps < 64'(noise))
                amps = 64'd0;
            r.current_rms    = clip32(amps);
            r.is_calibration = 1'b0;
        end
        else
        begin
            p        = n * 64'(sq_acc);
            q        = 64'(sum_acc) * 64'(sum_acc);
            t        = (p > q) ? p - q : 64'd0;
            v        = ((t / n) << 16) / n;
            zero_ofs = 20'((64'(sum_acc) << 8) / n);
            base_rms = clip32(counts_to_amps(floor_root(v << 16)));
            r.current_rms    = '0;
            r.is_calibration = 1'b1;
        end
        r.offset_now   = zero_ofs;
        r.baseline_now = base_rms;
        sq_acc  = '0;
        sum_acc = '0;
        win_cnt = '0;
        return 1'b1;
    endfunction

    task automatic offer_sample(input logic m, input logic [11:0] s, input bit known,
                                input reading_t want);
        reading_t r;
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
        begin
            smp_if.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct);
        end
        smp_if.valid  <= 1'b1;
        smp_if.mode   <= m;
        smp_if.sample <= s;
        do
            @(posedge clk);
        while (!smp_if.ready);
        if (rms_predict(m, s, r))
            pending_readings.push_back(known ? want : r);
    endtask

    // only between windows, once every reading is out
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [31:0] val);
        smp_if.valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_WINDOW_LENGTH:    win_len = val[15:0];
            CFG_CALIBRATION_GAIN: gain    = val[23:0];
            CFG_NOISE_THRESHOLD:  noise   = val;
            default: ;
        endcase
    endtask

    task automatic send_window(input logic m, input sample_shape_t shape);
        int unsigned len;
        int          center;
        int          swing;
        int          val;
        logic        beat_mode;
        len    = (win_len == 0) ? 1 : win_len;
        center = $urandom_range(4095);
        swing  = $urandom_range(600);
        for (int unsigned k = 0; k < len; k++)
        begin
            case (shape)
                SHAPE_CLUSTER:
                begin
                    val = center + int'($urandom_range(2 * swing)) - swing;
                    if (val < 0)
                        val = 0;
                    else if (val > 4095)
                        val = 4095;
                end
                SHAPE_SPREAD: val = $urandom_range(4095);
                default:      val = $urandom_range(1) ? 4095 : 0;
            endcase
            // mode after the first beat must be ignored
            beat_mode = (k == 0) ? m : 1'($urandom_range(1));
            offer_sample(beat_mode, 12'(val), 1'b0, '0);
        end
    endtask

    function automatic dir_row_t cfg_row(input logic [CFG_INDEX_BITS-1:0] idx,
                                         input logic [31:0] val);
        dir_row_t row;
        row           = '{default: '0};
        row.is_cfg    = 1'b1;
        row.reg_index = idx;
        row.reg_value = val;
        return row;
    endfunction

    function automatic dir_row_t beat_row(input logic m, input logic [11:0] s);
        dir_row_t row;
        row        = '{default: '0};
        row.mode   = m;
        row.sample = s;
        return row;
    endfunction

    function automatic dir_row_t known_row(input logic m, input logic [11:0] s,
                                           input logic [31:0] rms, input logic cal,
                                           input logic [19:0] ofs, input logic [31:0] base);
        dir_row_t row;
        row       = beat_row(m, s);
        row.known = 1'b1;
        row.want  = '{rms, cal, ofs, base};
        return row;
    endfunction

    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                res_if.ready <= 1'b0;
            end
            else
                res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        reading_t got;
        reading_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            got = '{res_if.current_rms, res_if.is_calibration,
                    res_if.offset_now, res_if.baseline_now};
            if (pending_readings.size() == 0)
            begin
                if (bad_readings < 10)
                    $display("%0t: unexpected beat rms=%0d cal=%0b ofs=%0d base=%0d",
                             $time, got.current_rms, got.is_calibration,
                             got.offset_now, got.baseline_now);
                bad_readings++;
            end
            else
            begin
                want = pending_readings.pop_front();
                if (got.current_rms !== want.current_rms
                    || got.is_calibration !== want.is_calibration
                    || got.offset_now !== want.offset_now
                    || got.baseline_now !== want.baseline_now)
                begin
                    if (bad_readings < 10)
                    begin
                        $write("%0t: mismatch exp rms=%0d cal=%0b ofs=%0d base=%0d",
                               $time, want.current_rms, want.is_calibration,
                               want.offset_now, want.baseline_now);
                        $display(" got rms=%0d cal=%0b ofs=%0d base=%0d",
                                 got.current_rms, got.is_calibration,
                                 got.offset_now, got.baseline_now);
                    end
                    bad_readings++;
                end
            end
        end
    end

    // cycles without a beat on either channel
    always @(posedge clk)
    begin
        int unsigned quiet;
        if (!rst_n || (smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        dir_row_t      dir_rows[$];
        int unsigned   phase_beats;
        logic [31:0]   pick;
        sample_shape_t shape;

        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_WINDOW_LENGTH;
        cfg_data      <= '0;
        smp_if.valid  <= 1'b0;
        smp_if.mode   <= MODE_MEASURE;
        smp_if.sample <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 30;
        rx_idle_pct = 83;

        dir_rows.push_back(cfg_row(CFG_WINDOW_LENGTH, 32'd0));  // zero acts as one
        dir_rows.push_back(known_row(MODE_MEASURE, 12'd0, '0, 1'b0, '0, '0));
        dir_rows.push_back(known_row(MODE_CALIBRATE, 12'd4095, '0, 1'b1, 20'hFFF00, '0));
        dir_rows.push_back(known_row(MODE_MEASURE, 12'd4095, '0, 1'b0, 20'hFFF00, '0));
        dir_rows.push_back(beat_row(MODE_MEASURE, 12'd0));
        dir_rows.push_back(known_row(MODE_CALIBRATE, 12'd0, '0, 1'b1, '0, '0));
        dir_rows.push_back(beat_row(MODE_MEASURE, 12'd4095));
        dir_rows.push_back(cfg_row(CFG_CALIBRATION_GAIN, GAIN_MAX));
        dir_rows.push_back(beat_row(MODE_MEASURE, 12'd4095));
        dir_rows.push_back(beat_row(MODE_MEASURE, 12'd2048));
        dir_rows.push_back(cfg_row(CFG_NOISE_THRESHOLD, NOISE_MAX));
        dir_rows.push_back(known_row(MODE_MEASURE, 12'd4095, '0, 1'b0, '0, '0));
        dir_rows.push_back(cfg_row(CFG_NOISE_THRESHOLD, 32'd0));
        dir_rows.push_back(beat_row(MODE_MEASURE, 12'd1));
        dir_rows.push_back(cfg_row(CFG_WINDOW_LENGTH, 32'd2));
        dir_rows.push_back(beat_row(MODE_CALIBRATE, 12'd0));
        dir_rows.push_back(beat_row(MODE_MEASURE, 12'd4095));   // mid-window mode change
        dir_rows.push_back(beat_row(MODE_MEASURE, 12'd0));
        dir_rows.push_back(beat_row(MODE_CALIBRATE, 12'd4095));
        dir_rows.push_back(cfg_row(CFG_CALIBRATION_GAIN, 32'd0));
        dir_rows.push_back(beat_row(MODE_MEASURE, 12'd100));
        dir_rows.push_back(beat_row(MODE_MEASURE, 12'd3000));
        dir_rows.push_back(cfg_row(CFG_WINDOW_LENGTH, 32'd3));
        dir_rows.push_back(cfg_row(CFG_CALIBRATION_GAIN, 32'd65536));
        dir_rows.push_back(cfg_row(CFG_NOISE_THRESHOLD, 32'd3277));
        dir_rows.push_back(beat_row(MODE_CALIBRATE, 12'd1));
        dir_rows.push_back(beat_row(MODE_CALIBRATE, 12'd2));
        dir_rows.push_back(beat_row(MODE_CALIBRATE, 12'd3));

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
                write_reg(dir_rows[i].reg_index, dir_rows[i].reg_value);
            else
                offer_sample(dir_rows[i].mode, dir_rows[i].sample, dir_rows[i].known,
                             dir_rows[i].want);
        end

        for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase / 4)
                0:       begin tx_idle_pct = 30; rx_idle_pct = 83; end
                1:       begin tx_idle_pct = 83; rx_idle_pct = 30; end
                default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase

            case ($urandom_range(4))
                0:       pick = 32'd1;
                1:       pick = 32'd2;
                2:       pick = $urandom_range(8, 3);
                3:       pick = $urandom_range(40, 9);
                default: pick = $urandom_range(3);
            endcase
            // single-beat windows make the stalled output back up fastest
            write_reg(CFG_WINDOW_LENGTH, (phase == 8) ? 32'd1 : pick);

            case ($urandom_range(3))
                0:       pick = 32'd65536;
                1:       pick = $urandom_range(GAIN_MAX);
                2:       pick = $urandom_range(262143);
                default: pick = GAIN_MAX;
            endcase
            write_reg(CFG_CALIBRATION_GAIN, pick);

            case ($urandom_range(3))
                0:       pick = 32'd0;
                1:       pick = 32'd3277;
                2:       pick = $urandom_range(200000);
                default: pick = $urandom();
            endcase
            write_reg(CFG_NOISE_THRESHOLD, pick);

            if (phase == 8)
                hold_req = 1'b1;

            phase_beats = 0;
            while (phase_beats < PHASE_BEATS)
            begin
                pick = $urandom_range(99);
                if (pick < 60)
                    shape = SHAPE_CLUSTER;
                else if (pick < 85)
                    shape = SHAPE_SPREAD;
                else
                    shape = SHAPE_RAILS;
                send_window(($urandom_range(9) < 3) ? MODE_CALIBRATE : MODE_MEASURE, shape);
                phase_beats += (win_len == 0) ? 1 : win_len;
            end
        end

        // rail-to-rail windows to finish
        write_reg(CFG_WINDOW_LENGTH, TAIL_WINDOW);
        write_reg(CFG_NOISE_THRESHOLD, 32'd0);
        send_window(MODE_MEASURE, SHAPE_RAILS);
        send_window(MODE_CALIBRATE, SHAPE_RAILS);

        smp_if.valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (bad_readings == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/trms_pkg.sv
rtl/trms_in_if.sv
rtl/trms_out_if.sv
rtl/trms_dp.sv
rtl/trms_ctrl.sv
rtl/true_rms_current_meter.sv
tb/tb_true_rms_current_meter.sv
